[rtl/matrix3x3_inverse_core_defines.svh]
// assertion macros for the 3x3 matrix inverse core
`ifndef MATRIX3X3_INVERSE_CORE_DEFINES_SVH
`define MATRIX3X3_INVERSE_CORE_DEFINES_SVH

// same-cycle implication
`define MI3_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error("mi3 check failed");

// next-cycle implication
`define MI3_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error("mi3 check failed");

`endif

[rtl/mi3_pkg.sv]
// shared types and constants for the 3x3 matrix inverse core
`default_nettype none
package mi3_pkg;

	localparam int NUM_ELEM = 9;

	// adj[k] = a[x]*a[y] - a[u]*a[v], row-major element indices
	localparam int ADJ_IDX [NUM_ELEM][4] = '{
		'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
		'{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
		'{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
	};

	typedef struct packed {
		logic adv;
		logic neg;
	} lane_ctl_t;

endpackage
`default_nettype wire

[rtl/mi3_div_lane.sv]
// pipelined restoring divider with rounding and saturation for one element
`default_nettype none
module mi3_div_lane #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic                      clk,
	input  mi3_pkg::lane_ctl_t        ctl,
	input  logic [2*DATA_WIDTH:0]     num,
	input  logic [3*DATA_WIDTH+2:0]   den,
	output logic [DATA_WIDTH-1:0]     quo,
	output logic                      ovf
);
	import mi3_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int AW = 2*W + 1;
	localparam int DW = 3*W + 3;
	localparam int NW = AW + 2*FRAC_BITS;
	localparam int TW = NW - W;
	localparam int RW = (DW + 1 > TW) ? DW + 1 : TW;
	localparam logic [W:0] LIM_POS = {2'b00, {(W-1){1'b1}}};
	localparam logic [W:0] LIM_NEG = {2'b01, {(W-1){1'b0}}};

	logic [NW-1:0] nfull;
	logic [TW-1:0] ntop;

	logic [RW-1:0] rem_s [0:W];
	logic [W-1:0]  low_s [0:W];
	logic [W-1:0]  quo_s [0:W];
	logic [DW-1:0] den_s [0:W];
	logic          neg_s [0:W];
	logic          big_s [0:W];

	logic [RW-1:0] rsh  [1:W];
	logic          ge   [1:W];

	logic          rnd;
	logic [W:0]    qr;
	logic [W:0]    qneg;
	logic [W-1:0]  res_sl;
	logic          ovf_sl;
	logic [W-1:0]  res_nxt;
	logic          ovf_nxt;

	assign nfull = {num, {(2*FRAC_BITS){1'b0}}};
	assign ntop  = nfull[NW-1:W];

	// quotient at or above 2^W saturates whatever the low bits
	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			rem_s[0] <= RW'(ntop);
			low_s[0] <= nfull[W-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den;
			neg_s[0] <= ctl.neg;
			big_s[0] <= RW'(ntop) >= RW'(den);
		end
	end

	for (genvar i = 1; i <= W; i++) begin : g_step
		assign rsh[i] = {rem_s[i-1][RW-2:0], low_s[i-1][W-1]};
		assign ge[i]  = rsh[i] >= RW'(den_s[i-1]);

		always_ff @(posedge clk) begin
			if (ctl.adv) begin
				rem_s[i] <= ge[i] ? rsh[i] - RW'(den_s[i-1]) : rsh[i];
				low_s[i] <= low_s[i-1] << 1;
				quo_s[i] <= {quo_s[i-1][W-2:0], ge[i]};
				den_s[i] <= den_s[i-1];
				neg_s[i] <= neg_s[i-1];
				big_s[i] <= big_s[i-1];
			end
		end
	end

	// round half away from zero on the magnitude, then saturate
	always_comb begin
		rnd  = {rem_s[W][RW-2:0], 1'b0} >= RW'(den_s[W]);
		qr   = {1'b0, quo_s[W]} + (W+1)'(rnd);
		qneg = ~qr + (W+1)'(1);
		if (neg_s[W]) begin
			ovf_nxt = big_s[W] || (qr > LIM_NEG);
			res_nxt = ovf_nxt ? {1'b1, {(W-1){1'b0}}} : qneg[W-1:0];
		end else begin
			ovf_nxt = big_s[W] || (qr > LIM_POS);
			res_nxt = ovf_nxt ? {1'b0, {(W-1){1'b1}}} : qr[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			res_sl <= res_nxt;
			ovf_sl <= ovf_nxt;
		end
	end

	assign quo = res_sl;
	assign ovf = ovf_sl;

endmodule
`default_nettype wire

[rtl/matrix3x3_inverse_core.sv]
// top level of the 3x3 fixed-point matrix inverse core
//
// channel  role    tvalid/tready       payload
// s_       input   s_tvalid/s_tready   s_tdata: a00..a22 signed
// m_       output  m_tvalid/m_tready   m_tdata: inv00..inv22, m_tuser: singular, overflow
//
// one matrix per cycle while the output is not stalled; each of the nine divider lanes
// computes one restoring quotient bit per stage
// one enable moves the whole pipeline; a stalled output freezes every stage
// asynchronous reset clears only the valid bits
`default_nettype none
module matrix3x3_inverse_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// a00, a01, a02, a10, a11, a12, a20, a21, a22 from bit 0 up
	input  logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22 from bit 0 up
	output logic [((9*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
	// singular, overflow from bit 0 up
	output logic [1:0] m_tuser
);
	import mi3_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int AW = 2*W + 1;
	localparam int DW = 3*W + 3;
	localparam int MW = NUM_ELEM * W;
	localparam int TDW = ((9*DATA_WIDTH+7)/8)*8;
	localparam int LAT = W + 9;

	logic adv;

	logic          vld_s  [1:LAT];
	logic [MW-1:0] mat_s  [1:LAT-1];
	logic          sing_s [6:LAT-1];

	logic signed [W-1:0]    a_in  [NUM_ELEM];
	logic signed [W-1:0]    a_s2  [3];
	logic signed [2*W-1:0]  prod_s1 [2*NUM_ELEM];
	logic signed [AW-1:0]   adj_s2 [NUM_ELEM];
	logic signed [AW-1:0]   adj_s3 [NUM_ELEM];
	logic signed [AW-1:0]   adj_s4 [NUM_ELEM];
	logic signed [AW-1:0]   adj_s5 [NUM_ELEM];
	logic signed [AW-1:0]   plo_s3 [3];
	logic signed [AW-1:0]   phi_s3 [3];
	logic signed [DW-1:0]   term_s4 [3];
	logic signed [DW-1:0]   det_s5;
	logic [AW-1:0]          nmag_s6 [NUM_ELEM];
	logic [DW-1:0]          dmag_s6;
	logic                   neg_s6 [NUM_ELEM];

	lane_ctl_t              lane_ctl [NUM_ELEM];
	logic [W-1:0]           lane_quo [NUM_ELEM];
	logic                   lane_ovf [NUM_ELEM];
	logic                   ovf_any;

	logic [MW-1:0]          out_inv_q;
	logic                   out_sing_q;
	logic                   out_ovf_q;

	assign adv      = !vld_s[LAT] || m_tready;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_tvalid;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_ELEM; k++) a_in[k] = $signed(s_tdata[k*W +: W]);
		for (int j = 0; j < 3; j++) a_s2[j] = $signed(mat_s[2][j*W +: W]);
	end

	// cofactor products, cofactors, split determinant products, determinant, magnitudes, signs
	always_ff @(posedge clk) begin
		if (adv) begin
			mat_s[1] <= s_tdata[MW-1:0];
			for (int i = 2; i <= LAT-1; i++) mat_s[i] <= mat_s[i-1];
			for (int k = 0; k < NUM_ELEM; k++) begin
				prod_s1[2*k]   <= a_in[ADJ_IDX[k][0]] * a_in[ADJ_IDX[k][1]];
				prod_s1[2*k+1] <= a_in[ADJ_IDX[k][2]] * a_in[ADJ_IDX[k][3]];
				adj_s2[k] <= AW'(prod_s1[2*k]) - AW'(prod_s1[2*k+1]);
				adj_s3[k] <= adj_s2[k];
				adj_s4[k] <= adj_s3[k];
				adj_s5[k] <= adj_s4[k];
			end
			for (int j = 0; j < 3; j++) begin
				plo_s3[j]  <= a_s2[j] * $signed({1'b0, adj_s2[3*j][W-1:0]});
				phi_s3[j]  <= a_s2[j] * $signed(adj_s2[3*j][AW-1:W]);
				term_s4[j] <= (DW'(phi_s3[j]) <<< W) + DW'(plo_s3[j]);
			end
			det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
			dmag_s6 <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			sing_s[6] <= det_s5 == '0;
			for (int k = 0; k < NUM_ELEM; k++) begin
				nmag_s6[k] <= adj_s5[k][AW-1] ? AW'(-adj_s5[k]) : AW'(adj_s5[k]);
				neg_s6[k]  <= adj_s5[k][AW-1] ^ det_s5[DW-1];
			end
			for (int i = 7; i <= LAT-1; i++) sing_s[i] <= sing_s[i-1];
		end
	end

	for (genvar k = 0; k < NUM_ELEM; k++) begin : g_lane
		assign lane_ctl[k] = '{adv: adv, neg: neg_s6[k]};

		mi3_div_lane #(
			.DATA_WIDTH (W),
			.FRAC_BITS  (FRAC_BITS)
		) u_lane (
			.clk (clk),
			.ctl (lane_ctl[k]),
			.num (nmag_s6[k]),
			.den (dmag_s6),
			.quo (lane_quo[k]),
			.ovf (lane_ovf[k])
		);
	end

	always_comb begin
		ovf_any = 1'b0;
		for (int k = 0; k < NUM_ELEM; k++) ovf_any = ovf_any | lane_ovf[k];
	end

	// singular matrix passes through unchanged
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NUM_ELEM; k++)
				out_inv_q[k*W +: W] <= sing_s[LAT-1] ? mat_s[LAT-1][k*W +: W] : lane_quo[k];
			out_sing_q <= sing_s[LAT-1];
			out_ovf_q  <= !sing_s[LAT-1] && ovf_any;
		end
	end

	assign m_tvalid = vld_s[LAT];
	assign m_tdata  = TDW'(out_inv_q);
	assign m_tuser  = {out_ovf_q, out_sing_q};

`include "matrix3x3_inverse_core_defines.svh"

	`MI3_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_s[1])
	`MI3_ASSERT_IMP(a_sing_no_ovf, m_tvalid, !(m_tuser[0] && m_tuser[1]))
	`MI3_ASSERT_NEXT(a_stall_freezes, !s_tready, vld_s[LAT] && $stable(out_sing_q))

endmodule
`default_nettype wire

[sim/matrix3x3_inverse_core_test.sv]
// testbench for the 3x3 fixed-point matrix inverse core: directed table then random matrices
`timescale 1ns / 100ps
`default_nettype none
module matrix3x3_inverse_core_test;

	localparam int DW = 32;
	localparam int TW = 9 * DW;
	localparam int RANDOM_ITEMS = 1400;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [1:0] FLAG_NONE = 2'b00;
	localparam logic [1:0] FLAG_SINGULAR = 2'b01;
	localparam logic [1:0] FLAG_OVERFLOW = 2'b10;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] Q_HALF = 32'h0000_8000;
	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	typedef enum int {MAT_FULL, MAT_MODEST, MAT_SINGULAR, MAT_TINY} mat_kind_t;

	typedef struct {
		logic [TW-1:0] inv;
		logic [1:0] flags;
	} inverse_t;

	typedef struct {
		logic [TW-1:0] m;
		bit typed;
		logic [TW-1:0] inv;
		logic [1:0] flags;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [TW-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [TW-1:0] m_tdata;
	logic [1:0] m_tuser;

	inverse_t pending_inverses[$];
	int send_idle = 13;
	int recv_idle = 57;
	int mismatches = 0;
	int received = 0;
	int hold_left = 0;
	bit hold_done = 0;
	bit stimulus_done = 0;
	longint cycles = 0;

	matrix3x3_inverse_core #(.DATA_WIDTH(DW), .FRAC_BITS(16)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic logic [TW-1:0] pack9(input logic [31:0] e0, e1, e2, e3, e4, e5,
		e6, e7, e8);
		return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
	endfunction

	function automatic logic [TW-1:0] diag(input logic [31:0] v);
		return pack9(v, 0, 0, 0, v, 0, 0, 0, v);
	endfunction

	// exact adjugate over determinant, rounded half away from zero, saturated; a singular matrix is returned unchanged
	function automatic inverse_t inverse_of(input logic [TW-1:0] m);
		logic signed [191:0] a[9];
		logic signed [191:0] adj[9];
		logic signed [191:0] det;
		logic [191:0] num, den, q, r;
		bit neg;
		inverse_t res;
		res.flags = FLAG_NONE;
		for (int i = 0; i < 9; i++) a[i] = 192'(signed'(m[DW*i +: DW]));
		adj[0] = a[4] * a[8] - a[5] * a[7];
		adj[1] = a[2] * a[7] - a[1] * a[8];
		adj[2] = a[1] * a[5] - a[2] * a[4];
		adj[3] = a[5] * a[6] - a[3] * a[8];
		adj[4] = a[0] * a[8] - a[2] * a[6];
		adj[5] = a[2] * a[3] - a[0] * a[5];
		adj[6] = a[3] * a[7] - a[4] * a[6];
		adj[7] = a[1] * a[6] - a[0] * a[7];
		adj[8] = a[0] * a[4] - a[1] * a[3];
		det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
		if (det == 0) begin
			res.inv = m;
			res.flags = FLAG_SINGULAR;
			return res;
		end
		den = det < 0 ? -det : det;
		for (int i = 0; i < 9; i++) begin
			neg = (adj[i] < 0) != (det < 0);
			num = (adj[i] < 0 ? -adj[i] : adj[i]) << 32;
			q = num / den;
			r = num - q * den;
			if ((r << 1) >= den) q = q + 1;
			if (!neg && q > 192'(Q_MAX)) begin
				q = 192'(Q_MAX);
				res.flags = FLAG_OVERFLOW;
			end else if (neg && q > 192'(Q_MIN)) begin
				q = 192'(Q_MIN);
				res.flags = FLAG_OVERFLOW;
			end
			res.inv[DW*i +: DW] = neg ? -q[31:0] : q[31:0];
		end
		return res;
	endfunction

	function automatic logic [31:0] modest_elem();
		return 32'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
	endfunction

	function automatic logic [TW-1:0] random_matrix(input mat_kind_t kind);
		logic [TW-1:0] m;
		for (int i = 0; i < 9; i++) begin
			case (kind)
			MAT_FULL: begin
				m[DW*i +: DW] = $urandom;
			end
			MAT_TINY: begin
				m[DW*i +: DW] = 32'($urandom_range(32)) - 32'd16;
			end
			default: begin
				m[DW*i +: DW] = modest_elem();
			end
			endcase
		end
		if (kind == MAT_SINGULAR) begin
			if ($urandom_range(1)) m[DW*6 +: 3*DW] = m[0 +: 3*DW];
			else m[DW*6 +: 3*DW] = '0;
		end
		return m;
	endfunction

	task automatic send_matrix(input logic [TW-1:0] m, input inverse_t expected);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= m;
		do @(posedge clk); while (!s_tready);
		pending_inverses.push_back(expected);
	endtask

	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		inverse_t expected;
		logic [TW-1:0] m;
		int pick;
		rows.push_back('{'0, 1, '0, FLAG_SINGULAR});
		rows.push_back('{diag(Q_ONE), 1, diag(Q_ONE), FLAG_NONE});
		rows.push_back('{diag(32'h0002_0000), 1, diag(Q_HALF), FLAG_NONE});
		rows.push_back('{diag(32'd1), 1, diag(Q_MAX), FLAG_OVERFLOW});
		rows.push_back('{diag(32'hffff_ffff), 1, diag(Q_MIN), FLAG_OVERFLOW});
		rows.push_back('{{9{Q_MAX}}, 1, {9{Q_MAX}}, FLAG_SINGULAR});
		rows.push_back('{{9{Q_MIN}}, 1, {9{Q_MIN}}, FLAG_SINGULAR});
		rows.push_back('{{9{32'hffff_ffff}}, 1, {9{32'hffff_ffff}}, FLAG_SINGULAR});
		rows.push_back('{diag(Q_MAX), 0, '0, FLAG_NONE});
		rows.push_back('{diag(Q_MIN), 0, '0, FLAG_NONE});
		rows.push_back('{pack9(Q_MAX, Q_MIN, 1, Q_MIN, Q_MAX, 0, 1, 0, Q_MAX), 0, '0, FLAG_NONE});
		rows.push_back('{pack9(Q_ONE, 32'h5555_aaaa, 0, 0, Q_ONE, 32'haaaa_5555, 0, 0, Q_MIN),
			0, '0, FLAG_NONE});
		rows.push_back('{pack9(32'h0003_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0003_0000,
			32'h0001_0000, 0, 32'h0001_0000, 32'h0003_0000), 0, '0, FLAG_NONE});
		rows.push_back('{pack9(0, 1, 0, 0, 0, 1, 1, 0, 0), 0, '0, FLAG_NONE});
		rows.push_back('{pack9(0, Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 32'hffff_0000), 0, '0, FLAG_NONE});
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			row = rows[i];
			if (row.typed) begin
				expected.inv = row.inv;
				expected.flags = row.flags;
			end else begin
				expected = inverse_of(row.m);
			end
			send_matrix(row.m, expected);
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3) begin
				send_idle = 57;
				recv_idle = 13;
			end else if (n == 2 * RANDOM_ITEMS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			pick = $urandom_range(99);
			if (pick < 20) m = random_matrix(MAT_FULL);
			else if (pick < 70) m = random_matrix(MAT_MODEST);
			else if (pick < 85) m = random_matrix(MAT_SINGULAR);
			else m = random_matrix(MAT_TINY);
			send_matrix(m, inverse_of(m));
		end
		s_tvalid <= 1'b0;
		stimulus_done = 1;
	end

	always @(posedge clk) begin
		inverse_t want;
		if (m_tvalid && m_tready) begin
			received <= received + 1;
			if (pending_inverses.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected transaction: data %h user %b",
					m_tdata, m_tuser);
			end else begin
				want = pending_inverses.pop_front();
				if (m_tdata !== want.inv || m_tuser[0] !== want.flags[0]
					|| m_tuser[1] !== want.flags[1]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("mismatch: expected %h/%b got %h/%b",
						want.inv, want.flags, m_tdata, m_tuser);
				end
			end
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!hold_done && received == 1000) begin
			hold_done <= 1;
			hold_left <= 300;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		while (pending_inverses.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
